### src/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and constants: bracket kinds, verdict codes, decoded word.
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam logic [7:0] CHAR_OPEN_ROUND   = 8'h28;
  localparam logic [7:0] CHAR_OPEN_SQUARE  = 8'h5B;
  localparam logic [7:0] CHAR_OPEN_CURLY   = 8'h7B;
  localparam logic [7:0] CHAR_CLOSE_ROUND  = 8'h29;
  localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5D;
  localparam logic [7:0] CHAR_CLOSE_CURLY  = 8'h7D;

  typedef enum logic [1:0] {
    KIND_ROUND  = 2'd0,
    KIND_SQUARE = 2'd1,
    KIND_CURLY  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    VERDICT_OK       = 2'd0,
    VERDICT_MISMATCH = 2'd1,
    VERDICT_UNCLOSED = 2'd2,
    VERDICT_OVERFLOW = 2'd3
  } verdict_t;

  typedef struct packed {
    logic  opening;
    logic  closing;
    kind_t kind;
    logic  last;
  } bbc_op_t;

endpackage

### src/bracket_balance_checker.sv
// A final byte is written into the queue when it is accepted; the stack
// update then pops it from the queue and registers its verdict on out_valid.
// Throughput: one byte per cycle; a final byte stalls only while the previous
// verdict is still held in the output register and not yet taken.
// Reset: clears the queue, the stack fill, the error flag and the output valid.
// ----------------------------------------------------------------------------
// bracket_balance_checker
// Checks that round, square and curly brackets in a byte stream are balanced.
// ----------------------------------------------------------------------------
module bracket_balance_checker
  import bbc_pkg::*;
#(
  parameter int STACK_DEPTH = 64
)(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  input  logic       last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       balanced,
  output logic [1:0] verdict
);

  logic    q_push;
  logic    q_push_ready;
  bbc_op_t q_push_data;
  logic    q_valid;
  bbc_op_t q_data;
  logic    q_pop;

  bbc_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_code (char_code),
    .last_char (last_char),
    .q_push    (q_push),
    .q_data    (q_push_data),
    .q_ready   (q_push_ready)
  );

  bbc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_push_data),
    .push_ready (q_push_ready),
    .pop_valid  (q_valid),
    .pop_data   (q_data),
    .pop        (q_pop)
  );

  bbc_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .balanced  (balanced),
    .verdict   (verdict)
  );

endmodule

### src/bbc_front.sv
// ----------------------------------------------------------------------------
// bbc_front
// Accepts text words and classifies each byte into a push, a pop or nothing.
// ----------------------------------------------------------------------------
module bbc_front
  import bbc_pkg::*;
(
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  input  logic       last_char,
  output logic       q_push,
  output bbc_op_t    q_data,
  input  logic       q_ready
);

  always_comb begin
    q_data.opening = 1'b0;
    q_data.closing = 1'b0;
    q_data.kind    = KIND_ROUND;
    q_data.last    = last_char;
    unique case (char_code)
      CHAR_OPEN_ROUND: begin
        q_data.opening = 1'b1;
        q_data.kind    = KIND_ROUND;
      end
      CHAR_OPEN_SQUARE: begin
        q_data.opening = 1'b1;
        q_data.kind    = KIND_SQUARE;
      end
      CHAR_OPEN_CURLY: begin
        q_data.opening = 1'b1;
        q_data.kind    = KIND_CURLY;
      end
      CHAR_CLOSE_ROUND: begin
        q_data.closing = 1'b1;
        q_data.kind    = KIND_ROUND;
      end
      CHAR_CLOSE_SQUARE: begin
        q_data.closing = 1'b1;
        q_data.kind    = KIND_SQUARE;
      end
      CHAR_CLOSE_CURLY: begin
        q_data.closing = 1'b1;
        q_data.kind    = KIND_CURLY;
      end
      default: begin
        q_data.opening = 1'b0;
      end
    endcase
  end

  assign in_ready = q_ready;
  assign q_push   = in_valid & q_ready;

endmodule

### src/bbc_queue.sv
// ----------------------------------------------------------------------------
// bbc_queue
// Two-entry queue of decoded words between the front and the back.
// ----------------------------------------------------------------------------
module bbc_queue
  import bbc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bbc_op_t push_data,
  output logic    push_ready,
  output logic    pop_valid,
  output bbc_op_t pop_data,
  input  logic    pop
);

  bbc_op_t    entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### src/bbc_back.sv
// ----------------------------------------------------------------------------
// bbc_back
// Runs the bracket stack: top entry in a register, lower entries in a memory,
// the one below the top also read ahead; verdict held in an output register.
// ----------------------------------------------------------------------------
module bbc_back
  import bbc_pkg::*;
#(
  parameter int STACK_DEPTH = 64
)(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  bbc_op_t    q_data,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       balanced,
  output logic [1:0] verdict
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int FW = $clog2(STACK_DEPTH + 1);
  localparam logic [FW-1:0] FILL_FULL = FW'(STACK_DEPTH);

  kind_t    stack_mem [STACK_DEPTH];
  kind_t    top;
  kind_t    rd_data;
  kind_t    byp_data;
  kind_t    below;
  logic     byp_hit;
  logic [FW-1:0] fill;
  logic [FW-1:0] fill_after;
  logic [FW-1:0] fill_next;
  logic     err;
  verdict_t err_kind;
  logic     err_after;
  verdict_t kind_after;
  verdict_t verdict_now;
  logic     take;
  logic     active;
  logic     push_ok;
  logic     pop_ok;
  logic     overflow;
  logic     mismatch;
  logic     wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  assign below  = byp_hit ? byp_data : rd_data;
  assign q_pop  = take;
  assign take   = q_valid & (~q_data.last | ~out_valid | out_ready);
  assign active = ~err;

  always_comb begin
    push_ok  = q_data.opening & active & (fill != FILL_FULL);
    overflow = q_data.opening & active & (fill == FILL_FULL);
    pop_ok   = q_data.closing & active & (fill != '0) & (top == q_data.kind);
    mismatch = q_data.closing & active & ~((fill != '0) & (top == q_data.kind));

    priority if (push_ok) begin
      fill_after = fill + FW'(1);
    end else if (pop_ok) begin
      fill_after = fill - FW'(1);
    end else begin
      fill_after = fill;
    end

    err_after  = err | overflow | mismatch;
    kind_after = err_kind;
    if (overflow) begin
      kind_after = VERDICT_OVERFLOW;
    end else if (mismatch) begin
      kind_after = VERDICT_MISMATCH;
    end

    if (err_after) begin
      verdict_now = kind_after;
    end else if (fill_after != '0) begin
      verdict_now = VERDICT_UNCLOSED;
    end else begin
      verdict_now = VERDICT_OK;
    end

    if (!take) begin
      fill_next = fill;
    end else if (q_data.last) begin
      fill_next = '0;
    end else begin
      fill_next = fill_after;
    end

    wr_en   = take & push_ok & (fill != '0);
    wr_addr = AW'(fill - FW'(1));
    rd_addr = AW'(fill_next - FW'(2));
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= top;
    end
    rd_data  <= stack_mem[rd_addr];
    byp_hit  <= wr_en & (wr_addr == rd_addr);
    byp_data <= top;
  end

  always_ff @(posedge clk) begin
    if (take & push_ok) begin
      top <= q_data.kind;
    end else if (take & pop_ok) begin
      top <= below;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      err      <= 1'b0;
      err_kind <= VERDICT_OK;
    end else if (take) begin
      fill <= fill_next;
      if (q_data.last) begin
        err      <= 1'b0;
        err_kind <= VERDICT_OK;
      end else begin
        err      <= err_after;
        err_kind <= kind_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take & q_data.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take & q_data.last) begin
      verdict  <= verdict_now;
      balanced <= (verdict_now == VERDICT_OK);
    end
  end

endmodule

### tb/bracket_balance_checker_test.sv
// ----------------------------------------------------------------------------
// bracket_balance_checker_test
// Streams short texts through the bracket checker, one byte per word, and
// compares every verdict with an in-bench stack predictor. Directed texts hit
// each fault kind; random texts are mostly well-nested with noise bytes, plus
// broken, unclosed, bracket-soup and deep texts that can reach overflow.
// ----------------------------------------------------------------------------
module bracket_balance_checker_test;
  import bbc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = 64;
  localparam int ITEM_GOAL  = 500;
  localparam int STALL_MAX  = 2000;
  localparam int HOLD_START = 150;
  localparam int HOLD_END   = 450;
  localparam int QUIET_LO   = 500;
  localparam int QUIET_HI   = 750;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } word_t;

  typedef struct packed {
    logic     balanced;
    verdict_t verdict;
  } verdict_rec_t;

  typedef enum int {
    SHAPE_NEST,
    SHAPE_BROKEN,
    SHAPE_OPEN,
    SHAPE_NOISE,
    SHAPE_SOUP,
    SHAPE_DEEP
  } shape_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] char_code = 8'h00;
  logic       last_char = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       balanced;
  logic [1:0] verdict;

  word_t        pending_words[$];
  verdict_rec_t expected_verdicts[$];
  logic [7:0]   draft[$];

  kind_t        kind_stack[DEPTH];
  int unsigned  stack_fill;
  logic         fault_seen;
  verdict_t     fault_kind;

  logic in_taken = 1'b0;
  int   cycle_count = 0;
  int   sink_count = 0;
  int   stall_count = 0;
  int   fail_count = 0;
  int   counted = 0;

  bracket_balance_checker #(
    .STACK_DEPTH(DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .char_code(char_code),
    .last_char(last_char),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .balanced (balanced),
    .verdict  (verdict)
  );

  always #5 clk = ~clk;

  function automatic logic idle_roll();
    if (cycle_count >= QUIET_LO && cycle_count < QUIET_HI) return 1'b0;
    return $urandom_range(0, 99) < 11;
  endfunction

  function automatic kind_t random_kind();
    return kind_t'($urandom_range(0, 2));
  endfunction

  function automatic logic [7:0] open_char(input kind_t k);
    case (k)
      KIND_ROUND:  return CHAR_OPEN_ROUND;
      KIND_SQUARE: return CHAR_OPEN_SQUARE;
      default:     return CHAR_OPEN_CURLY;
    endcase
  endfunction

  function automatic logic [7:0] close_char(input kind_t k);
    case (k)
      KIND_ROUND:  return CHAR_CLOSE_ROUND;
      KIND_SQUARE: return CHAR_CLOSE_SQUARE;
      default:     return CHAR_CLOSE_CURLY;
    endcase
  endfunction

  function automatic logic is_bracket(input logic [7:0] c);
    return c == CHAR_OPEN_ROUND || c == CHAR_OPEN_SQUARE || c == CHAR_OPEN_CURLY ||
           c == CHAR_CLOSE_ROUND || c == CHAR_CLOSE_SQUARE || c == CHAR_CLOSE_CURLY;
  endfunction

  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    // all bracket codes sit below 8'h80, so flipping the top bit clears them
    return is_bracket(c) ? (c ^ 8'h80) : c;
  endfunction

  function automatic logic [7:0] any_bracket();
    return $urandom_range(0, 1) ? open_char(random_kind()) : close_char(random_kind());
  endfunction

  task automatic add_string(input string s);
    for (int n = 0; n < s.len(); n++) draft = {draft, 8'(s[n])};
  endtask

  task automatic commit_text();
    word_t w;
    if (draft.size() == 0) draft = {draft, noise_char()};
    foreach (draft[n]) begin
      w.code = draft[n];
      w.last = (n == draft.size() - 1);
      pending_words = {pending_words, w};
      counted++;
    end
    draft.delete();
  endtask

  task automatic build_nest(input int len, input int max_depth, input logic close_all);
    kind_t opens[$];
    kind_t k;
    int    pick;
    for (int n = 0; n < len; n++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4 && opens.size() < max_depth) begin
        k = random_kind();
        opens = {opens, k};
        draft = {draft, open_char(k)};
      end else if (pick < 8 && opens.size() > 0) begin
        k = opens.pop_back();
        draft = {draft, close_char(k)};
      end else begin
        draft = {draft, noise_char()};
      end
    end
    if (close_all) begin
      while (opens.size() > 0) begin
        k = opens.pop_back();
        draft = {draft, close_char(k)};
      end
    end else if (opens.size() == 0) begin
      draft = {draft, open_char(random_kind())};
    end
  endtask

  task automatic build_deep(input int opens_n, input int closes_n);
    kind_t opens[$];
    kind_t k;
    for (int n = 0; n < opens_n; n++) begin
      k = random_kind();
      opens = {opens, k};
      draft = {draft, open_char(k)};
    end
    for (int n = 0; n < closes_n && opens.size() > 0; n++) begin
      k = opens.pop_back();
      draft = {draft, close_char(k)};
    end
  endtask

  task automatic add_random_text();
    shape_t shape;
    int     pick;
    int     n;
    pick = $urandom_range(0, 99);
    if (pick < 55)      shape = SHAPE_NEST;
    else if (pick < 70) shape = SHAPE_BROKEN;
    else if (pick < 80) shape = SHAPE_OPEN;
    else if (pick < 88) shape = SHAPE_NOISE;
    else if (pick < 98) shape = SHAPE_SOUP;
    else                shape = SHAPE_DEEP;
    case (shape)
      SHAPE_NEST: build_nest($urandom_range(1, 16), 12, 1'b1);
      SHAPE_BROKEN: begin
        build_nest($urandom_range(2, 16), 12, 1'b1);
        draft[$urandom_range(0, draft.size() - 1)] = any_bracket();
      end
      SHAPE_OPEN: build_nest($urandom_range(1, 12), 12, 1'b0);
      SHAPE_NOISE: begin
        repeat ($urandom_range(1, 6)) draft = {draft, noise_char()};
      end
      SHAPE_SOUP: begin
        repeat ($urandom_range(1, 10)) draft = {draft, any_bracket()};
      end
      default: begin
        n = $urandom_range(60, 66);
        build_deep(n, $urandom_range(n - 3, n));
      end
    endcase
    commit_text();
  endtask

  task automatic track_brackets(input logic [7:0] code, input logic last);
    kind_t        k;
    logic         bracket;
    logic         opening;
    verdict_t     v;
    verdict_rec_t rec;
    bracket = 1'b1;
    opening = 1'b0;
    k = KIND_ROUND;
    case (code)
      CHAR_OPEN_ROUND:   begin k = KIND_ROUND;  opening = 1'b1; end
      CHAR_OPEN_SQUARE:  begin k = KIND_SQUARE; opening = 1'b1; end
      CHAR_OPEN_CURLY:   begin k = KIND_CURLY;  opening = 1'b1; end
      CHAR_CLOSE_ROUND:  k = KIND_ROUND;
      CHAR_CLOSE_SQUARE: k = KIND_SQUARE;
      CHAR_CLOSE_CURLY:  k = KIND_CURLY;
      default:           bracket = 1'b0;
    endcase
    if (bracket && !fault_seen) begin
      if (opening) begin
        if (stack_fill >= DEPTH) begin
          fault_seen = 1'b1;
          fault_kind = VERDICT_OVERFLOW;
        end else begin
          kind_stack[stack_fill] = k;
          stack_fill++;
        end
      end else if (stack_fill == 0 || kind_stack[stack_fill - 1] != k) begin
        fault_seen = 1'b1;
        fault_kind = VERDICT_MISMATCH;
      end else begin
        stack_fill--;
      end
    end
    if (last) begin
      if (fault_seen)          v = fault_kind;
      else if (stack_fill != 0) v = VERDICT_UNCLOSED;
      else                     v = VERDICT_OK;
      rec.balanced = (v == VERDICT_OK);
      rec.verdict  = v;
      expected_verdicts = {expected_verdicts, rec};
      stack_fill = 0;
      fault_seen = 1'b0;
      fault_kind = VERDICT_OK;
    end
  endtask

  always @(negedge clk) begin
    word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_words.size() > 0 && !idle_roll()) begin
        w = pending_words.pop_front();
        in_valid  <= 1'b1;
        char_code <= w.code;
        last_char <= w.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      sink_count <= sink_count + 1;
      if (sink_count >= HOLD_START && sink_count < HOLD_END) out_ready <= 1'b0;
      else out_ready <= !idle_roll();
    end
  end

  always @(posedge clk) begin
    verdict_rec_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      cycle_count <= cycle_count + 1;
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          $error("unexpected verdict word: balanced %0d verdict %0d", balanced, verdict);
          fail_count++;
        end else begin
          want = expected_verdicts.pop_front();
          if (balanced !== want.balanced) begin
            $error("balanced: expected %0d, actual %0d", want.balanced, balanced);
            fail_count++;
          end
          if (verdict !== want.verdict) begin
            $error("verdict: expected %0d, actual %0d", want.verdict, verdict);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) track_brackets(char_code, last_char);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_count <= 0;
      end else if (stall_count + 1 >= STALL_MAX) begin
        $display("bracket_balance_checker: mismatch");
        $finish;
      end else begin
        stall_count <= stall_count + 1;
      end
    end
  end

  initial begin
    stack_fill = 0;
    fault_seen = 1'b0;
    fault_kind = VERDICT_OK;

    draft = {draft, 8'h00};
    commit_text();
    add_string("()");
    commit_text();
    add_string("[{()}]");
    commit_text();
    add_string(")");
    commit_text();
    add_string("(]");
    commit_text();
    // first fault is kept, later bytes ignored
    add_string("(])(");
    commit_text();
    add_string("{");
    draft = {draft, 8'hFF};
    commit_text();
    add_string("[}");
    commit_text();
    add_string("{)");
    commit_text();

    build_deep(DEPTH, DEPTH);
    commit_text();
    build_deep(DEPTH + 1, 1);
    commit_text();
    while (counted < ITEM_GOAL) add_random_text();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || in_valid || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    if (fail_count == 0 && expected_verdicts.size() == 0) begin
      $display("bracket_balance_checker: match");
    end else begin
      $display("bracket_balance_checker: mismatch");
    end
    $finish;
  end

endmodule
